### rtl/eec_pkg.sv
package eec_pkg;

    // status of the shared divide unit as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

### rtl/eec_in_if.sv
interface eec_in_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;
    logic signed [WIDTH-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

### rtl/eec_out_if.sv
interface eec_out_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] coef_value;
    logic signed [WIDTH-1:0] coef_modulus;

    modport source (output valid, output coef_value, output coef_modulus, input ready);
    modport sink   (input valid, input coef_value, input coef_modulus, output ready);
endinterface

### rtl/eec_div.sv
module eec_div #(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDTH-1:0]  i_dividend,
    input  logic [WIDTH-1:0]  i_divisor,
    input  logic [WIDTH-1:0]  i_mul_x,
    input  logic [WIDTH-1:0]  i_mul_y,
    output eec_pkg::t_div_sts o_sts,
    output logic [WIDTH-1:0]  o_rem,
    output logic [WIDTH-1:0]  o_prod_x,
    output logic [WIDTH-1:0]  o_prod_y
);
    localparam int CW = $clog2(WIDTH);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_dvd, n_dvd;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_mb, n_mb;
    logic [WIDTH-1:0] r_mx, n_mx;
    logic [WIDTH-1:0] r_my, n_my;
    logic [WIDTH-1:0] r_acc_x, n_acc_x;
    logic [WIDTH-1:0] r_acc_y, n_acc_y;
    logic             r_neg_a, n_neg_a;
    logic             r_neg_q, n_neg_q;

    logic [WIDTH-1:0] w_rem_sh;
    logic             w_ge;

    // remainder stays below the divisor magnitude, so its top bit is always clear
    assign w_rem_sh = {r_rem[WIDTH-2:0], r_dvd[WIDTH-1]};
    assign w_ge     = (w_rem_sh >= r_mb);

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_mb    = r_mb;
        n_mx    = r_mx;
        n_my    = r_my;
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_neg_a = r_neg_a;
        n_neg_q = r_neg_q;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CW'(WIDTH - 1);
            n_neg_a = i_dividend[WIDTH-1];
            n_neg_q = i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
            n_dvd   = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_mb    = i_divisor[WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_rem   = '0;
            n_mx    = i_mul_x;
            n_my    = i_mul_y;
            n_acc_x = '0;
            n_acc_y = '0;
        end else if (r_busy) begin
            n_dvd   = {r_dvd[WIDTH-2:0], 1'b0};
            n_rem   = w_ge ? (w_rem_sh - r_mb) : w_rem_sh;
            // quotient bits arrive msb first: horner accumulation of |q| * x2, |q| * y2
            n_acc_x = {r_acc_x[WIDTH-2:0], 1'b0} + (w_ge ? r_mx : '0);
            n_acc_y = {r_acc_y[WIDTH-2:0], 1'b0} + (w_ge ? r_my : '0);
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_mb    <= n_mb;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_acc_x <= n_acc_x;
        r_acc_y <= n_acc_y;
        r_neg_a <= n_neg_a;
        r_neg_q <= n_neg_q;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_neg_a ? (~r_rem + 1'b1) : r_rem;
    assign o_prod_x   = r_neg_q ? (~r_acc_x + 1'b1) : r_acc_x;
    assign o_prod_y   = r_neg_q ? (~r_acc_y + 1'b1) : r_acc_y;
endmodule

### rtl/extended_euclid_coefficients.sv
// Extended Euclid with truncating division: for each (value, modulus) word it returns x and y
// with value*x + modulus*y equal to the last nonzero remainder (gcd up to sign); a zero
// modulus gives x = 1, y = 0. All arithmetic wraps at WIDTH bits. One item at a time: the
// input is ready only while the block is idle. Each Euclid round runs one restoring divide
// in the shared divide unit, which also forms q*x2 and q*y2 on the fly, and one pass through
// S_CHECK; the result word is offered in S_OUT once a remainder of zero is reached.
module extended_euclid_coefficients #(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eec_in_if.sink    i_in,
    eec_out_if.source o_out
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_a1, n_a1;
    logic [WIDTH-1:0] r_a2, n_a2;
    logic [WIDTH-1:0] r_x1, n_x1;
    logic [WIDTH-1:0] r_y1, n_y1;
    logic [WIDTH-1:0] r_x2, n_x2;
    logic [WIDTH-1:0] r_y2, n_y2;

    logic              w_start;
    eec_pkg::t_div_sts w_div_sts;
    logic [WIDTH-1:0]  w_rem;
    logic [WIDTH-1:0]  w_prod_x;
    logic [WIDTH-1:0]  w_prod_y;

    eec_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_a1),
        .i_divisor  (r_a2),
        .i_mul_x    (r_x2),
        .i_mul_y    (r_y2),
        .o_sts      (w_div_sts),
        .o_rem      (w_rem),
        .o_prod_x   (w_prod_x),
        .o_prod_y   (w_prod_y)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.coef_value   = r_x1;
    assign o_out.coef_modulus = r_y1;

    always_comb begin
        n_state = r_state;
        n_a1    = r_a1;
        n_a2    = r_a2;
        n_x1    = r_x1;
        n_y1    = r_y1;
        n_x2    = r_x2;
        n_y2    = r_y2;
        w_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_a1    = i_in.value;
                    n_a2    = i_in.modulus;
                    n_x1    = WIDTH'(1);
                    n_y1    = '0;
                    n_x2    = '0;
                    n_y2    = WIDTH'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_a2 == '0) begin
                    n_state = S_OUT;
                end else begin
                    w_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_a1    = r_a2;
                    n_a2    = w_rem;
                    n_x1    = r_x2;
                    n_y1    = r_y2;
                    n_x2    = r_x1 - w_prod_x;
                    n_y2    = r_y1 - w_prod_y;
                    n_state = S_CHECK;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a1 <= n_a1;
        r_a2 <= n_a2;
        r_x1 <= n_x1;
        r_y1 <= n_y1;
        r_x2 <= n_x2;
        r_y2 <= n_y2;
    end

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("divide finished outside a round");
    a_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> (r_a2 != '0) && !w_div_sts.busy)
        else $error("divide started on zero divisor or while busy");
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CHECK) && !i_in.ready)
        else $error("accepted word did not start a run");
    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.busy |-> (r_state == S_DIV))
        else $error("divide unit busy outside a round");
`endif
endmodule
